// ===== src/min_key_event_queue_defines.svh =====
// ----------------------------------------------------------------------------
// min_key_event_queue_defines.svh
// Assertion macros used by the event queue top level.
// ----------------------------------------------------------------------------
`ifndef MIN_KEY_EVENT_QUEUE_DEFINES_SVH
`define MIN_KEY_EVENT_QUEUE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define MKEQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mkeq assertion failed");

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define MKEQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mkeq assertion failed");

`endif

// ===== src/mkeq_pkg.sv =====
// ----------------------------------------------------------------------------
// mkeq_pkg
// Types and constants of the min-key event queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mkeq_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int KEY_W  = 48;
  localparam int REC_W  = 64;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 9;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [REC_W-1:0] rec;
  } entry_t;

  typedef struct packed {
    logic             opcode;
    logic [KEY_W-1:0] time_key;
    logic [REC_W-1:0] record;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  out_time;
    logic [REC_W-1:0]  out_record;
    logic [OCC_W-1:0]  occupancy;
  } res_word_t;

endpackage

`default_nettype wire

// ===== src/mkeq_if.sv =====
// ----------------------------------------------------------------------------
// mkeq_if
// Valid/ready channels of the event queue: request words and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mkeq_in_if
  import mkeq_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [KEY_W-1:0] time_key;
  logic [REC_W-1:0] record;

  modport source (output valid, output opcode, output time_key, output record,
                  input ready);
  modport sink   (input valid, input opcode, input time_key, input record,
                  output ready);
endinterface

interface mkeq_out_if
  import mkeq_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [KEY_W-1:0]  out_time;
  logic [REC_W-1:0]  out_record;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, output status, output out_time, output out_record,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_time, input out_record,
                  input occupancy, output ready);
endinterface

`default_nettype wire

// ===== src/mkeq_ram.sv =====
// ----------------------------------------------------------------------------
// mkeq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mkeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/mkeq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mkeq_ctrl
// Queue sequencer: append on insert, linear min scan plus swap on extract.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mkeq_ctrl
  import mkeq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_word_t  in_word_i,
  output logic           res_valid_o,
  input  wire logic      res_ready_i,
  output res_word_t      res_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SWAP,
    S_RESP
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q;
  logic [ADDR_W-1:0] idx_q;
  logic [ADDR_W-1:0] best_idx_q;
  entry_t            best_q;
  entry_t            last_q;
  res_word_t         res_q;

  logic              accept;
  logic              full;
  logic [CNT_W-1:0]  last_pos;
  logic              take;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t            cand;

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = res_q;

  assign accept   = in_valid_i && in_ready_o;
  assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign last_pos = count_q - CNT_W'(1);
  assign cand     = entry_t'(ram_rdata);
  assign take     = (idx_q == '0) || (cand.key < best_q.key);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_q[ADDR_W-1:0];
    ram_wdata = '{key: in_word_i.time_key, rec: in_word_i.record};
    ram_raddr = '0;
    unique case (state_q)
      S_IDLE: begin
        ram_we = accept && (in_word_i.opcode == OP_INSERT) && !full;
      end
      S_SCAN: begin
        ram_raddr = idx_q + ADDR_W'(1);
      end
      S_SWAP: begin
        ram_we    = 1'b1;
        ram_waddr = best_idx_q;
        ram_wdata = last_q;
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  mkeq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      idx_q      <= '0;
      best_idx_q <= '0;
      best_q     <= '0;
      last_q     <= '0;
      res_q      <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            res_q.out_time   <= '0;
            res_q.out_record <= '0;
            if (in_word_i.opcode == OP_INSERT) begin
              state_q <= S_RESP;
              if (full) begin
                res_q.status    <= ST_FULL;
                res_q.occupancy <= OCC_W'(count_q);
              end else begin
                count_q         <= count_q + CNT_W'(1);
                res_q.status    <= ST_OK;
                res_q.occupancy <= OCC_W'(count_q + CNT_W'(1));
              end
            end else if (count_q == '0) begin
              state_q         <= S_RESP;
              res_q.status    <= ST_EMPTY;
              res_q.occupancy <= OCC_W'(count_q);
            end else begin
              state_q <= S_SCAN;
              idx_q   <= '0;
            end
          end
        end
        S_SCAN: begin
          if (take) begin
            best_q     <= cand;
            best_idx_q <= idx_q;
          end
          if (CNT_W'(idx_q) == last_pos) begin
            last_q  <= cand;
            state_q <= S_SWAP;
          end else begin
            idx_q <= idx_q + ADDR_W'(1);
          end
        end
        S_SWAP: begin
          count_q          <= last_pos;
          res_q.status     <= ST_OK;
          res_q.out_time   <= best_q.key;
          res_q.out_record <= best_q.rec;
          res_q.occupancy  <= OCC_W'(last_pos);
          state_q          <= S_RESP;
        end
        S_RESP: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/min_key_event_queue.sv =====
// ----------------------------------------------------------------------------
// min_key_event_queue
// Event queue that returns the event with the smallest timestamp.
// ----------------------------------------------------------------------------
// Usage:
//   evt_i carries request words: opcode 0 appends (time_key, record) after
//   the last held event; opcode 1 removes the event with the smallest key,
//   the lowest slot winning on equal keys, and moves the last event into
//   the freed slot. Every request gives exactly one word on res_o: status,
//   extracted key and record (zero unless a successful extract) and the
//   occupancy after the request.
//   Timing: insert and any rejected request pass through the controller's
//   result register and then the output register to res_o; an extract
//   first scans, one event RAM read per cycle, then does one swap write.
//   One request is in work at a time; the next request is taken as soon
//   as the previous one has handed its result to the output register.
//   Reset empties the queue at once; RAM contents need no clearing.
//   When the receiver stalls the result holds in the output register and
//   at most one more request is worked on until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "min_key_event_queue_defines.svh"

module min_key_event_queue
  import mkeq_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mkeq_in_if.sink     evt_i,
  mkeq_out_if.source  res_o
);

  in_word_t  in_word;
  res_word_t core_res;
  logic      core_valid;
  logic      core_ready;
  logic      out_valid_q;
  res_word_t out_q;

  assign in_word = '{opcode: evt_i.opcode, time_key: evt_i.time_key, record: evt_i.record};

  mkeq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (evt_i.valid),
    .in_ready_o  (evt_i.ready),
    .in_word_i   (in_word),
    .res_valid_o (core_valid),
    .res_ready_i (core_ready),
    .res_o       (core_res)
  );

  assign core_ready = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_ready) begin
      out_valid_q <= core_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_ready && core_valid) begin
      out_q <= core_res;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.status     = out_q.status;
  assign res_o.out_time   = out_q.out_time;
  assign res_o.out_record = out_q.out_record;
  assign res_o.occupancy  = out_q.occupancy;

  `MKEQ_ASSERT_NXT(a_busy_after_accept, evt_i.valid && evt_i.ready, !evt_i.ready)
  `MKEQ_ASSERT_IMP(a_empty_occ, res_o.valid && (res_o.status == ST_EMPTY), res_o.occupancy == '0)
  `MKEQ_ASSERT_IMP(a_full_occ, res_o.valid && (res_o.status == ST_FULL), res_o.occupancy == OCC_W'(QUEUE_DEPTH))
  `MKEQ_ASSERT_IMP(a_err_zero, res_o.valid && (res_o.status != ST_OK), (res_o.out_time == '0) && (res_o.out_record == '0))

endmodule

`default_nettype wire

// ===== tb/sv/min_key_event_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_key_event_queue_tb
// Self-checking bench for the min-key event queue: random and directed
// insert/extract words go in, and every result word is checked against a
// linear-scan queue model kept in the bench, under several handshake paces.
// ----------------------------------------------------------------------------

module min_key_event_queue_tb
  import mkeq_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 90;
  localparam int DRAIN_CYCLES   = 20;

  typedef enum int {
    PACE_STEADY,
    PACE_SRC_IDLE,
    PACE_SNK_STALL,
    PACE_BOTH
  } pace_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mkeq_in_if  evt_if ();
  mkeq_out_if res_if ();

  min_key_event_queue dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .evt_i  (evt_if),
    .res_o  (res_if)
  );

  always #6 clk = ~clk;

  pace_e pace = PACE_STEADY;

  in_word_t  event_backlog[$];
  res_word_t expected_results[$];

  // queue model
  logic [KEY_W-1:0] key_mem[QUEUE_DEPTH];
  logic [REC_W-1:0] rec_mem[QUEUE_DEPTH];
  int unsigned      model_held = 0;

  int n_inserts = 0;
  int n_full = 0;
  int n_extracts = 0;
  int n_empty = 0;
  int peak_held = 0;
  int n_checked = 0;
  int errors = 0;

  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  int gen_held = 0;

  function automatic res_word_t apply_event_op(in_word_t w);
    res_word_t   r;
    int unsigned best;
    r = '0;
    r.status = ST_OK;
    if (w.opcode == OP_INSERT) begin
      n_inserts++;
      if (model_held >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
        n_full++;
      end else begin
        key_mem[model_held] = w.time_key;
        rec_mem[model_held] = w.record;
        model_held++;
      end
    end else begin
      n_extracts++;
      if (model_held == 0) begin
        r.status = ST_EMPTY;
        n_empty++;
      end else begin
        best = 0;
        for (int unsigned s = 1; s < model_held; s++) begin
          if (key_mem[s] < key_mem[best]) best = s;
        end
        r.out_time = key_mem[best];
        r.out_record = rec_mem[best];
        key_mem[best] = key_mem[model_held - 1];
        rec_mem[best] = rec_mem[model_held - 1];
        model_held--;
      end
    end
    if (model_held > peak_held) peak_held = model_held;
    r.occupancy = OCC_W'(model_held);
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(7))
      0: k = '0;
      1: k = '1;
      2, 3: k = KEY_W'($urandom_range(7));
      default: k = KEY_W'({$urandom, $urandom});
    endcase
    return k;
  endfunction

  function automatic logic [REC_W-1:0] pick_rec();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_word(opcode_e op, logic [KEY_W-1:0] k, logic [REC_W-1:0] rec);
    in_word_t w;
    w.opcode = op;
    w.time_key = k;
    w.record = rec;
    event_backlog.insert(event_backlog.size(), w);
    if (op == OP_INSERT && gen_held < QUEUE_DEPTH) gen_held++;
    if (op == OP_EXTRACT && gen_held > 0) gen_held--;
  endtask

  task automatic random_mix(int count, int insert_pct);
    for (int i = 0; i < count; i++) begin
      queue_word(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_EXTRACT,
                 pick_key(), pick_rec());
    end
  endtask

  task automatic settle();
    while (event_backlog.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  // driver
  logic src_go;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      evt_if.valid <= 1'b0;
    end else begin
      src_go = evt_if.valid;
      if (evt_if.valid && evt_if.ready) begin
        expected_results.insert(expected_results.size(),
                                apply_event_op(event_backlog.pop_front()));
        src_go = 1'b0;
      end
      if (!src_go && event_backlog.size() != 0) begin
        if (!((pace == PACE_SRC_IDLE && $urandom_range(99) < 67) ||
              (pace == PACE_BOTH && $urandom_range(99) < 36))) begin
          src_go = 1'b1;
          evt_if.opcode <= event_backlog[0].opcode;
          evt_if.time_key <= event_backlog[0].time_key;
          evt_if.record <= event_backlog[0].record;
        end
      end
      evt_if.valid <= src_go;
    end
  end

  // monitor and checker
  res_word_t got;
  res_word_t want;
  logic      snk_go;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got.status = res_if.status;
        got.out_time = res_if.out_time;
        got.out_record = res_if.out_record;
        got.occupancy = res_if.occupancy;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result word: status=%0d time=%h rec=%h occ=%0d",
                     got.status, got.out_time, got.out_record, got.occupancy);
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (got.status != want.status || got.out_time != want.out_time ||
              got.out_record != want.out_record || got.occupancy != want.occupancy) begin
            errors++;
            if (errors <= 10)
              $display("mismatch on word %0d: exp st=%0d t=%h r=%h occ=%0d, got st=%0d t=%h r=%h occ=%0d",
                       n_checked, want.status, want.out_time, want.out_record,
                       want.occupancy, got.status, got.out_time, got.out_record,
                       got.occupancy);
          end
        end
      end
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        snk_go = 1'b0;
      end else begin
        snk_go = !((pace == PACE_SNK_STALL && $urandom_range(99) < 67) ||
                   (pace == PACE_BOTH && $urandom_range(99) < 36));
      end
      res_if.ready <= snk_go;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    evt_if.valid = 1'b0;
    evt_if.opcode = OP_INSERT;
    evt_if.time_key = '0;
    evt_if.record = '0;
    res_if.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed: empty extract, extremes, ties, alternating bits, last-slot extract
    pace = PACE_STEADY;
    queue_word(OP_EXTRACT, '1, '1);
    queue_word(OP_INSERT, '1, '1);
    queue_word(OP_INSERT, '0, '0);
    queue_word(OP_INSERT, 48'd5, 64'h1111_2222_3333_4444);
    queue_word(OP_INSERT, 48'd5, 64'h5555_6666_7777_8888);
    queue_word(OP_INSERT, '0, 64'hdead_beef_0000_0001);
    queue_word(OP_INSERT, 48'haaaa_aaaa_aaaa, 64'haaaa_aaaa_aaaa_aaaa);
    queue_word(OP_INSERT, 48'h5555_5555_5555, 64'h5555_5555_5555_5555);
    repeat (8) queue_word(OP_EXTRACT, '0, '0);
    queue_word(OP_EXTRACT, '0, '0);
    queue_word(OP_INSERT, 48'h0000_0010_0000, 64'h0123_4567_89ab_cdef);
    queue_word(OP_INSERT, 48'h0000_0020_0000, 64'hfedc_ba98_7654_3210);
    queue_word(OP_EXTRACT, '0, '0);
    queue_word(OP_EXTRACT, '0, '0);
    settle();

    // long output hold-off while requests keep coming
    hold_reqs++;
    random_mix(60, 60);
    settle();

    pace = PACE_SRC_IDLE;
    random_mix(80, 50);
    settle();

    pace = PACE_SNK_STALL;
    while (gen_held < QUEUE_DEPTH) queue_word(OP_INSERT, pick_key(), pick_rec());
    repeat (3) queue_word(OP_INSERT, pick_key(), pick_rec());
    random_mix(30, 45);
    settle();

    pace = PACE_BOTH;
    random_mix(100, 40);
    settle();

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d words: %0d inserts (%0d into a full queue), %0d extracts",
             n_checked, n_inserts, n_full, n_extracts);
    $display("  (%0d on an empty queue), peak occupancy %0d, %0d errors",
             n_empty, peak_held, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
